// ===== src/fcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcgr_pkg
// shared types and constants of the reduced fraction comparator
// ----------------------------------------------------------------------------
`default_nettype none

package fcgr_pkg;

  localparam int unsigned ValueWidthDefault = 64;
  localparam int unsigned OrderWidth        = 2;
  localparam int unsigned OutDataWidth      = 8;

  typedef enum logic [OrderWidth-1:0] {
    ORDER_LESS    = 2'd0,
    ORDER_EQUAL   = 2'd1,
    ORDER_GREATER = 2'd2
  } order_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_CHECK,
    ST_GCD_WAIT,
    ST_RED_NUM,
    ST_RED_NUM_WAIT,
    ST_RED_DEN,
    ST_RED_DEN_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_CMP,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== src/fcgr_div.sv =====
// ----------------------------------------------------------------------------
// fcgr_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
`default_nettype none

module fcgr_div import fcgr_pkg::*; #(
  parameter int unsigned ValueWidth = ValueWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ValueWidth-1:0] dividend_i,
  input  wire logic [ValueWidth-1:0] divisor_i,
  output logic                       done_o,
  output logic      [ValueWidth-1:0] quotient_o,
  output logic      [ValueWidth-1:0] remainder_o
);

  localparam int unsigned CntWidth = $clog2(ValueWidth + 1);

  logic [ValueWidth-1:0] rem_q, quo_q, dvs_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  busy_q, done_q;
  logic [ValueWidth:0]   rem_shift, rem_diff;
  logic                  fits;

  assign rem_shift = {rem_q, quo_q[ValueWidth-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign fits      = rem_shift >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(ValueWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_diff[ValueWidth-1:0] : rem_shift[ValueWidth-1:0];
      quo_q <= {quo_q[ValueWidth-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== src/fcgr_mul.sv =====
// ----------------------------------------------------------------------------
// fcgr_mul
// shift-add multiplier, keeps the low bits of the product
// ----------------------------------------------------------------------------
`default_nettype none

module fcgr_mul import fcgr_pkg::*; #(
  parameter int unsigned ValueWidth = ValueWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ValueWidth-1:0] mcand_i,
  input  wire logic [ValueWidth-1:0] mplier_i,
  output logic                       done_o,
  output logic      [ValueWidth-1:0] product_o
);

  localparam int unsigned CntWidth = $clog2(ValueWidth + 1);

  logic [ValueWidth-1:0] acc_q, mcand_q, mplier_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(ValueWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
      mcand_q  <= {mcand_q[ValueWidth-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[ValueWidth-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

// ===== src/fraction_compare_gcd_reduced.sv =====
// ----------------------------------------------------------------------------
// fraction_compare_gcd_reduced
// compares two unsigned fractions after reducing each by its gcd
//
// s_axis carries one item of four values n1, d1, n2, d2. each fraction is
// reduced by euclid (a shared restoring divider), then n1*d2 and n2*d1 are
// formed on a shift-add multiplier and compared, low ValueWidth bits only.
// a fraction 0/0 is left as is and raises zero_over_zero on tuser.
// each fraction that is not 0/0 takes two reducing divisions after its
// euclid steps, of which there are at most 92 per fraction at 64 bits,
// fewer for small values.
// one item at a time: s_axis_tready is high only while idle, so the block
// takes no new item until the result of the last one has been taken.
// the result is held on m_axis until m_axis_tready; a stalled receiver
// keeps the block from taking the next item.
// reset returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_compare_gcd_reduced import fcgr_pkg::*; #(
  parameter int unsigned ValueWidth = ValueWidthDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // first_numerator, first_denominator, second_numerator, second_denominator
  input  wire logic [((4*ValueWidth+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // order
  output logic      [OutDataWidth-1:0]               m_axis_tdata,
  // zero_over_zero
  output logic      [0:0]                            m_axis_tuser
);

  localparam int unsigned W = ValueWidth;

  state_e              state_q, state_d;
  logic [W-1:0]        n1_q, d1_q, n2_q, d2_q;
  logic [W-1:0]        x_q, y_q, lhs_q, rhs_q;
  logic                sel_q, zoz_q;
  order_e              ord_q;

  logic                div_start, div_done, mul_start, mul_done;
  logic [W-1:0]        div_dividend, div_divisor, div_quo, div_rem;
  logic [W-1:0]        mul_a, mul_b, mul_p;

  fcgr_div #(.ValueWidth(W)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  fcgr_mul #(.ValueWidth(W)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .done_o   (mul_done),
    .product_o(mul_p)
  );

  // operand selection
  always_comb begin
    case (state_q)
      ST_RED_NUM: begin
        div_dividend = sel_q ? n2_q : n1_q;
        div_divisor  = x_q;
      end
      ST_RED_DEN: begin
        div_dividend = sel_q ? d2_q : d1_q;
        div_divisor  = x_q;
      end
      default: begin
        div_dividend = x_q;
        div_divisor  = y_q;
      end
    endcase
    mul_a = sel_q ? n2_q : n1_q;
    mul_b = sel_q ? d1_q : d2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mul_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_GCD_CHECK;
      end
      ST_GCD_CHECK: begin
        if (y_q != '0) begin
          div_start = 1'b1;
          state_d   = ST_GCD_WAIT;
        end else if (x_q != '0) begin
          state_d = ST_RED_NUM;
        end else if (!sel_q) begin
          state_d = ST_GCD_CHECK;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_GCD_WAIT: begin
        if (div_done) state_d = ST_GCD_CHECK;
      end
      ST_RED_NUM: begin
        div_start = 1'b1;
        state_d   = ST_RED_NUM_WAIT;
      end
      ST_RED_NUM_WAIT: begin
        if (div_done) state_d = ST_RED_DEN;
      end
      ST_RED_DEN: begin
        div_start = 1'b1;
        state_d   = ST_RED_DEN_WAIT;
      end
      ST_RED_DEN_WAIT: begin
        if (div_done) state_d = sel_q ? ST_MUL : ST_GCD_CHECK;
      end
      ST_MUL: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) state_d = sel_q ? ST_CMP : ST_MUL;
      end
      ST_CMP: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        n1_q  <= s_axis_tdata[W-1:0];
        d1_q  <= s_axis_tdata[2*W-1:W];
        n2_q  <= s_axis_tdata[3*W-1:2*W];
        d2_q  <= s_axis_tdata[4*W-1:3*W];
        x_q   <= s_axis_tdata[W-1:0];
        y_q   <= s_axis_tdata[2*W-1:W];
        sel_q <= 1'b0;
        zoz_q <= 1'b0;
      end
      ST_GCD_CHECK: begin
        if (y_q == '0 && x_q == '0) begin
          zoz_q <= 1'b1;
          if (!sel_q) begin
            sel_q <= 1'b1;
            x_q   <= n2_q;
            y_q   <= d2_q;
          end else begin
            sel_q <= 1'b0;
          end
        end
      end
      ST_GCD_WAIT: begin
        if (div_done) begin
          x_q <= y_q;
          y_q <= div_rem;
        end
      end
      ST_RED_NUM_WAIT: begin
        if (div_done) begin
          if (sel_q) n2_q <= div_quo;
          else       n1_q <= div_quo;
        end
      end
      ST_RED_DEN_WAIT: begin
        if (div_done) begin
          if (sel_q) begin
            d2_q  <= div_quo;
            sel_q <= 1'b0;
          end else begin
            d1_q  <= div_quo;
            sel_q <= 1'b1;
            x_q   <= n2_q;
            y_q   <= d2_q;
          end
        end
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (sel_q) rhs_q <= mul_p;
          else       lhs_q <= mul_p;
          sel_q <= ~sel_q;
        end
      end
      ST_CMP: begin
        if (lhs_q < rhs_q)      ord_q <= ORDER_LESS;
        else if (lhs_q > rhs_q) ord_q <= ORDER_GREATER;
        else                    ord_q <= ORDER_EQUAL;
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {{(OutDataWidth-OrderWidth){1'b0}}, ord_q};
  assign m_axis_tuser  = zoz_q;

  a_ports_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ord_q == ORDER_LESS || ord_q == ORDER_EQUAL ||
                       ord_q == ORDER_GREATER))
    else $error("unused order code on output");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (div_divisor != '0))
    else $error("divider started with a zero divisor");

  a_units_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !div_done && !mul_done)
    else $error("arithmetic unit finished while result pending");

endmodule

`default_nettype wire
